// ===== src/tmf_pkg.sv =====
// Shared constants, microcode word type and microcode table of the trimmed mean filter.
package tmf_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEPT     = 2'd1;
  localparam logic [CFG_W-1:0] HIST_LEN_RST = 5'd16;
  localparam logic [CFG_W-1:0] KEPT_RST     = 5'd8;

  // Command codes of the input channel.
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Sequencer step addresses.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] ST_READ  = 3'd1;
  localparam logic [STEP_W-1:0] ST_DRAIN = 3'd2;
  localparam logic [STEP_W-1:0] ST_SORT  = 3'd3;
  localparam logic [STEP_W-1:0] ST_SUM   = 3'd4;
  localparam logic [STEP_W-1:0] ST_DIVI  = 3'd5;
  localparam logic [STEP_W-1:0] ST_DIV   = 3'd6;
  localparam logic [STEP_W-1:0] ST_OUT   = 3'd7;

  // Jump conditions.
  localparam logic [1:0] CND_ALWAYS   = 2'd0;
  localparam logic [1:0] CND_CNT_END  = 2'd1;
  localparam logic [1:0] CND_ADD      = 2'd2;
  localparam logic [1:0] CND_OUT_FREE = 2'd3;

  // Step counter limits.
  localparam logic [1:0] LIM_LEN  = 2'd0;
  localparam logic [1:0] LIM_SORT = 2'd1;
  localparam logic [1:0] LIM_SUM  = 2'd2;
  localparam logic [1:0] LIM_DIV  = 2'd3;

  typedef struct packed {
    logic              in_rdy;
    logic              rd_en;
    logic              acc_clr;
    logic              sort_en;
    logic              sum_en;
    logic              div_init;
    logic              div_en;
    logic              out_ld;
    logic [1:0]        cond;
    logic [1:0]        lim;
    logic [STEP_W-1:0] next;
  } ucw_t;

  // The control program: one word per step. A step repeats until its
  // condition holds, then jumps to its successor.
  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    w      = '0;
    w.cond = CND_ALWAYS;
    w.lim  = LIM_LEN;
    unique case (step)
      ST_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond   = CND_ADD;
        w.next   = ST_READ;
      end
      ST_READ: begin
        w.rd_en = 1'b1;
        w.cond  = CND_CNT_END;
        w.lim   = LIM_LEN;
        w.next  = ST_DRAIN;
      end
      ST_DRAIN: begin
        w.acc_clr = 1'b1;
        w.next    = ST_SORT;
      end
      ST_SORT: begin
        w.sort_en = 1'b1;
        w.cond    = CND_CNT_END;
        w.lim     = LIM_SORT;
        w.next    = ST_SUM;
      end
      ST_SUM: begin
        w.sum_en = 1'b1;
        w.cond   = CND_CNT_END;
        w.lim    = LIM_SUM;
        w.next   = ST_DIVI;
      end
      ST_DIVI: begin
        w.div_init = 1'b1;
        w.next     = ST_DIV;
      end
      ST_DIV: begin
        w.div_en = 1'b1;
        w.cond   = CND_CNT_END;
        w.lim    = LIM_DIV;
        w.next   = ST_OUT;
      end
      ST_OUT: begin
        w.out_ld = 1'b1;
        w.cond   = CND_OUT_FREE;
        w.next   = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== src/tmf_if.sv =====
// Valid/ready stream interfaces for the filter's input and result channels.
interface tmf_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, command, sample, input ready);
  modport sink   (input valid, command, sample, output ready);
endinterface

interface tmf_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mean;

  modport source (output valid, mean, input ready);
  modport sink   (input valid, mean, output ready);
endinterface

// ===== src/trimmed_mean_filter_top.sv =====
// Trimmed mean filter: sample ring, microcoded sort, windowed sum and divider.
//
//   Channel   Direction  Handshake          Payload
//   in_s      sink       valid/ready        command (1), sample (SAMPLE_BITS, signed)
//   out_s     source     valid/ready        mean (SAMPLE_BITS, signed)
//   cfg_*     sink       cfg_we only        cfg_index (2), cfg_wdata (5)
//
// A clear command empties the ring and produces no result. An add command runs
// the read, drain, sort, sum, divider set-up, divide and output steps until the
// result is in the output register. Its pace is set by the single read port of
// the ring, the L + 1 passes of the odd-even sort, where L is the effective
// history length, and the one-bit-a-cycle divider. Reset is synchronous and
// active low; it empties the ring through its valid bits. A result waiting in
// the output register does not block the next input transfer; only a second
// result stalls the sequencer.
module trimmed_mean_filter_top #(
  parameter int MAX_LENGTH  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tmf_in_if.sink                         in_s,
  tmf_out_if.source                      out_s,
  input  logic                           cfg_we,
  input  logic [tmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmf_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int IDX_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int LEN_W = $clog2(MAX_LENGTH + 1);
  localparam int EXT_W = (LEN_W > tmf_pkg::CFG_W) ? LEN_W : tmf_pkg::CFG_W;
  localparam int SUM_W = SAMPLE_BITS + LEN_W;
  localparam int CNT_W = $clog2(((MAX_LENGTH + 1) > SUM_W) ? (MAX_LENGTH + 1) : SUM_W);

  // Configuration registers.
  logic [tmf_pkg::CFG_W-1:0] hist_len_r;
  logic [tmf_pkg::CFG_W-1:0] kept_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_len_r <= tmf_pkg::HIST_LEN_RST;
      kept_r     <= tmf_pkg::KEPT_RST;
    end else if (cfg_we) begin
      if (cfg_index == tmf_pkg::REG_HIST_LEN) begin
        hist_len_r <= cfg_wdata;
      end else if (cfg_index == tmf_pkg::REG_KEPT) begin
        kept_r <= cfg_wdata;
      end
    end
  end

  // Effective length and kept count, and the window that follows from them.
  // A zero length or count acts as one; the count never exceeds the length.
  logic [EXT_W-1:0] hl_x;
  logic [EXT_W-1:0] kc_x;
  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] kept_eff;
  logic [LEN_W-1:0] trim;
  logic [LEN_W-1:0] skip;
  logic [LEN_W-1:0] top_skip;
  logic [LEN_W-1:0] sum_last;

  always_comb begin
    hl_x = EXT_W'(hist_len_r);
    if (hl_x == '0) begin
      hl_x = EXT_W'(1);
    end
    if (hl_x > EXT_W'(MAX_LENGTH)) begin
      hl_x = EXT_W'(MAX_LENGTH);
    end
    eff_len = LEN_W'(hl_x);
    kc_x = EXT_W'(kept_r);
    if (kc_x == '0) begin
      kc_x = EXT_W'(1);
    end
    if (kc_x > EXT_W'(eff_len)) begin
      kc_x = EXT_W'(eff_len);
    end
    kept_eff = LEN_W'(kc_x);
    trim     = eff_len - kept_eff;
    skip     = trim >> 1;
    // The sum step reads the sorted entries from the largest down, so the
    // entries dropped at the top are the larger half of the trimmed ones.
    top_skip = trim - skip;
    sum_last = eff_len - skip - LEN_W'(1);
  end

  // Sequencer: step address, step counter and the current control word.
  logic [tmf_pkg::STEP_W-1:0] step_r;
  logic [CNT_W-1:0]           cnt_r;
  tmf_pkg::ucw_t              uw;
  logic                       cond_ok;
  logic [CNT_W-1:0]           lim_val;
  logic                       in_xfer;
  logic                       add_xfer;
  logic                       out_free;
  logic                       out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_mean_r;

  assign uw       = tmf_pkg::ucode(step_r);
  assign in_s.ready = uw.in_rdy;
  assign in_xfer  = in_s.valid && uw.in_rdy;
  assign add_xfer = in_xfer && (in_s.command == tmf_pkg::CMD_ADD);
  assign out_free = !out_valid_r || out_s.ready;

  always_comb begin
    unique case (uw.lim)
      tmf_pkg::LIM_LEN:  lim_val = CNT_W'(eff_len) - CNT_W'(1);
      tmf_pkg::LIM_SORT: lim_val = CNT_W'(eff_len);
      tmf_pkg::LIM_SUM:  lim_val = CNT_W'(sum_last);
      tmf_pkg::LIM_DIV:  lim_val = CNT_W'(SUM_W - 1);
    endcase
    unique case (uw.cond)
      tmf_pkg::CND_ALWAYS:   cond_ok = 1'b1;
      tmf_pkg::CND_CNT_END:  cond_ok = (cnt_r == lim_val);
      tmf_pkg::CND_ADD:      cond_ok = add_xfer;
      tmf_pkg::CND_OUT_FREE: cond_ok = out_free;
    endcase
  end

  // Every jump clears the counter, so each step starts counting from zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= tmf_pkg::ST_IDLE;
      cnt_r  <= '0;
    end else begin
      step_r <= cond_ok ? uw.next : step_r;
      cnt_r  <= cond_ok ? '0 : cnt_r + CNT_W'(1);
    end
  end

  // Sample ring. Entries without a valid bit read as zero, which covers both
  // reset and the clear command without a sweep.
  logic [SAMPLE_BITS-1:0] ring_mem [MAX_LENGTH];
  logic [MAX_LENGTH-1:0]  ring_vld_r;
  logic [IDX_W-1:0]       wpos_r;
  logic [LEN_W-1:0]       pos_eff;
  logic [LEN_W-1:0]       pos_inc;
  logic [LEN_W-1:0]       pos_nxt;

  always_comb begin
    // A write position left beyond a lowered length restarts at entry zero.
    pos_eff = (LEN_W'(wpos_r) >= eff_len) ? '0 : LEN_W'(wpos_r);
    pos_inc = pos_eff + LEN_W'(1);
    pos_nxt = (pos_inc >= eff_len) ? '0 : pos_inc;
  end

  always_ff @(posedge clk) begin
    if (add_xfer) begin
      ring_mem[pos_eff[IDX_W-1:0]] <= in_s.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      wpos_r     <= '0;
    end else if (in_xfer) begin
      if (in_s.command == tmf_pkg::CMD_CLEAR) begin
        ring_vld_r <= '0;
      end else begin
        ring_vld_r[pos_eff[IDX_W-1:0]] <= 1'b1;
        wpos_r <= IDX_W'(pos_nxt);
      end
    end
  end

  // Registered read port, addressed by the step counter during the read step.
  logic [SAMPLE_BITS-1:0]        rd_data_r;
  logic                          rd_ok_r;
  logic                          rd_vld_r;
  logic signed [SAMPLE_BITS-1:0] load_val;

  always_ff @(posedge clk) begin
    rd_data_r <= ring_mem[cnt_r[IDX_W-1:0]];
    rd_ok_r   <= ring_vld_r[cnt_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= uw.rd_en;
    end
  end

  assign load_val = rd_ok_r ? signed'(rd_data_r) : '0;

  // Work lanes. Loaded entries shift in from the top, so the live window is
  // the upper L lanes and dead lanes stay below it through the sort.
  logic signed [SAMPLE_BITS-1:0] work_v_r [MAX_LENGTH];
  logic [MAX_LENGTH-1:0]         work_live_r;
  logic signed [SAMPLE_BITS-1:0] sort_v [MAX_LENGTH];

  // One odd-even transposition pass; the counter's low bit picks the pairs.
  always_comb begin
    for (int i = 0; i < MAX_LENGTH; i++) begin
      sort_v[i] = work_v_r[i];
    end
    for (int i = 0; i < MAX_LENGTH - 1; i++) begin
      if ((i[0] == cnt_r[0]) && work_live_r[i] && (work_v_r[i] > work_v_r[i+1])) begin
        sort_v[i]   = work_v_r[i+1];
        sort_v[i+1] = work_v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_live_r <= '0;
    end else if (in_xfer) begin
      work_live_r <= '0;
    end else if (rd_vld_r) begin
      work_live_r <= {1'b1, work_live_r[MAX_LENGTH-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      for (int i = 0; i < MAX_LENGTH - 1; i++) begin
        work_v_r[i] <= work_v_r[i+1];
      end
      work_v_r[MAX_LENGTH-1] <= load_val;
    end else if (uw.sort_en) begin
      work_v_r <= sort_v;
    end else if (uw.sum_en) begin
      for (int i = 1; i < MAX_LENGTH; i++) begin
        work_v_r[i] <= work_v_r[i-1];
      end
    end
  end

  // Windowed sum over the sorted lanes, read at the top lane.
  logic signed [SUM_W-1:0] acc_r;
  logic signed [SUM_W-1:0] top_ext;

  assign top_ext = SUM_W'(work_v_r[MAX_LENGTH-1]);

  always_ff @(posedge clk) begin
    if (uw.acc_clr) begin
      acc_r <= '0;
    end else if (uw.sum_en && (cnt_r >= CNT_W'(top_skip))) begin
      acc_r <= acc_r + top_ext;
    end
  end

  // Restoring divider on the magnitude of the sum, one quotient bit a cycle.
  logic [SUM_W-1:0] dq_r;
  logic [LEN_W-1:0] rem_r;
  logic             neg_r;
  logic [LEN_W:0]   div_try;
  logic             div_ge;

  assign div_try = {rem_r, dq_r[SUM_W-1]};
  assign div_ge  = (div_try >= {1'b0, kept_eff});

  always_ff @(posedge clk) begin
    if (uw.div_init) begin
      neg_r <= acc_r[SUM_W-1];
      dq_r  <= acc_r[SUM_W-1] ? SUM_W'(-acc_r) : SUM_W'(acc_r);
      rem_r <= '0;
    end else if (uw.div_en) begin
      rem_r <= div_ge ? LEN_W'(div_try - {1'b0, kept_eff}) : div_try[LEN_W-1:0];
      dq_r  <= {dq_r[SUM_W-2:0], div_ge};
    end
  end

  // Output register; it is loaded only when empty or being emptied.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uw.out_ld && cond_ok) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.out_ld && cond_ok) begin
      out_mean_r <= neg_r ? -signed'(dq_r[SAMPLE_BITS-1:0]) : signed'(dq_r[SAMPLE_BITS-1:0]);
    end
  end

  assign out_s.valid = out_valid_r;
  assign out_s.mean  = out_mean_r;

endmodule

// ===== src/tmf_checker.sv =====
// Port-level checker for the trimmed mean filter and its bind to the top level.
module tmf_checker #(
  parameter int MEAN_W = 16
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_command,
  input logic              out_valid,
  input logic              out_ready,
  input logic [MEAN_W-1:0] out_mean
);

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result offered right after reset");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_mean)))
    else $error("stalled result changed or dropped");

  // An add keeps the sequencer busy, so input is refused next cycle.
  a_add_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_command == tmf_pkg::CMD_ADD)) |=> !in_ready)
    else $error("input taken while an add is in progress");

  // No result can appear in the cycle after any input transfer.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |=> !out_valid)
    else $error("result appeared one cycle after a transfer");

endmodule

bind trimmed_mean_filter_top tmf_checker #(.MEAN_W(SAMPLE_BITS)) u_tmf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_s.valid),
  .in_ready   (in_s.ready),
  .in_command (in_s.command),
  .out_valid  (out_s.valid),
  .out_ready  (out_s.ready),
  .out_mean   (out_s.mean)
);
